// File: rtl/chpe_pkg.sv
// Shared types and constants for the circular histogram peak engine.
package chpe_pkg;

	localparam int MAX_BINS_DEF = 256;
	localparam logic [8:0] BINS_RESET = 9'd36;
	localparam logic [30:0] PI_Q29 = 31'd1686629713;

	localparam logic [2:0] CMD_ADD   = 3'd0;
	localparam logic [2:0] CMD_SUM   = 3'd1;
	localparam logic [2:0] CMD_MAX   = 3'd2;
	localparam logic [2:0] CMD_PEAK  = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_RANGE = 2'd1;
	localparam logic [1:0] STS_FLAT  = 2'd2;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  bin_index;
		logic [7:0]  last_bin;
		logic [15:0] weight;
		logic        refine;
	} req_t;

	typedef struct packed {
		logic [31:0]        value;
		logic signed [15:0] angle;
		logic [1:0]         status;
		logic [31:0]        total_weight;
	} rsp_t;

endpackage

// File: rtl/circular_histogram_peak_engine.sv
// Circular histogram with add, range sum, max, peak angle and clear commands.
//
// A request is taken when start is high and busy is low. Every request gives
// exactly one response: done is high for one cycle with rsp valid, and the
// receiver must take it then. busy stays high from the request until the
// cycle before done, so a new request can be issued in the done cycle.
// Per command, with n the number of bins in use: add reads the bin and
// writes it back; range sum walks the bins from the first index to the
// last, wrapping; max walks all n bins; peak angle uses the 64-step shared
// divider (twice for a refined peak, once when plain or flat) and the
// 33-step shift-add multiplier; clear sweeps all MAX_BINS bins to zero.
// Bins live in one RAM with one read and one write port, one bin per cycle.
// A bad bin index is answered in the next cycle with status 1.
// After reset the block sweeps the RAM to zero, during which busy is high
// and no response is given. APB writes are taken at any time; bins_in_use
// sits at byte address 0 and resets to 36.
module circular_histogram_peak_engine #(
	parameter int MAX_BINS = chpe_pkg::MAX_BINS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  chpe_pkg::req_t req,
	output logic          done,
	output chpe_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [1:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int AW = $clog2(MAX_BINS);
	localparam int CW = ($clog2(MAX_BINS) + 1 > 7) ? $clog2(MAX_BINS) + 1 : 7;

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_CLR    = 5'd1;
	localparam logic [4:0] ST_ADD_RD = 5'd2;
	localparam logic [4:0] ST_ADD_WR = 5'd3;
	localparam logic [4:0] ST_WALK   = 5'd4;
	localparam logic [4:0] ST_WEND   = 5'd5;
	localparam logic [4:0] ST_PK_L   = 5'd6;
	localparam logic [4:0] ST_PK_M   = 5'd7;
	localparam logic [4:0] ST_PK_R   = 5'd8;
	localparam logic [4:0] ST_PK_D   = 5'd9;
	localparam logic [4:0] ST_DIV1   = 5'd10;
	localparam logic [4:0] ST_POS    = 5'd11;
	localparam logic [4:0] ST_ANG    = 5'd12;
	localparam logic [4:0] ST_MUL    = 5'd13;
	localparam logic [4:0] ST_DIVS   = 5'd14;
	localparam logic [4:0] ST_DIV2   = 5'd15;
	localparam logic [4:0] ST_FIN    = 5'd16;

	logic [4:0]  state_q;
	logic [8:0]  cfg_q;
	logic [8:0]  n_eff;
	logic [31:0] tot_q;
	logic [CW-1:0] it_q;
	logic        clr_rsp_q;
	logic        max_mode_q;
	logic        rv_q;
	logic [8:0]  idx_q;
	logic [8:0]  end_q;
	logic [8:0]  b0_q;
	logic [15:0] b0_weight_q;
	logic [8:0]  r_idx_q;
	logic        is_peak_q;
	logic [40:0] acc_q;
	logic [31:0] l_q;
	logic [31:0] m_q;
	logic        qneg_q;
	logic        flat_q;
	logic [63:0] quo_q;
	logic [39:0] div_q;
	logic [39:0] rem_q;
	logic signed [51:0] x_q;
	logic [32:0] mul_q;
	logic [65:0] prod_q;
	logic        done_q;
	logic [31:0] val_q;
	logic signed [15:0] ang_q;
	logic [1:0]  sts_q;

	// RAM ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;

	chpe_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_bins (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {23'd0, cfg_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= chpe_pkg::BINS_RESET;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			cfg_q <= pwdata[8:0];
		end
	end

	always_comb begin
		if (cfg_q < 9'd2) begin
			n_eff = 9'd2;
		end else if (32'(cfg_q) > 32'(MAX_BINS)) begin
			n_eff = 9'(MAX_BINS);
		end else begin
			n_eff = cfg_q;
		end
	end

	// Datapath helpers
	logic        accept;
	logic [32:0] add_sum;
	logic [31:0] add_sat;
	logic [32:0] tot_sum;
	logic [8:0]  idx_next;
	logic [8:0]  nb_l;
	logic [8:0]  nb_r;
	logic [40:0] trial;
	logic        trial_ok;
	logic signed [34:0] d_val;
	logic [34:0] d_mag;
	logic signed [51:0] x_c;
	logic signed [51:0] lim;
	logic signed [51:0] u_val;
	logic [65:0] prod_rnd;

	assign accept = start && !busy;
	assign add_sum = {1'b0, ram_rdata} + {17'd0, b0_weight_q};
	assign add_sat = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
	assign tot_sum = {1'b0, tot_q} + {17'd0, b0_weight_q};
	assign idx_next = (idx_q == n_eff - 9'd1) ? 9'd0 : idx_q + 9'd1;
	assign nb_l = (req.bin_index == 8'd0) ? n_eff - 9'd1 : {1'b0, req.bin_index} - 9'd1;
	assign nb_r = ({1'b0, req.bin_index} + 9'd1 < n_eff) ? {1'b0, req.bin_index} + 9'd1 : 9'd0;
	assign trial = {rem_q, quo_q[63]} - {1'b0, div_q};
	assign trial_ok = !trial[40];
	assign d_val = $signed({2'b00, m_q, 1'b0}) - $signed({3'b000, l_q})
		- $signed({3'b000, ram_rdata});
	assign lim = $signed({25'd0, n_eff, 18'd0});
	assign x_c = (x_q > lim) ? lim : ((x_q < -lim) ? -lim : x_q);
	assign u_val = (x_c <<< 1) - $signed({27'd0, n_eff, 16'd0});
	assign prod_rnd = prod_q + {26'd0, n_eff, 31'd0};

	logic [31:0] r_cnt;

	// l_q holds the left bin, m_q the middle bin; lr uses left minus right, computed below.
	assign r_cnt = ram_rdata;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = AW'(b0_q);
		ram_wdata = add_sat;
		ram_raddr = AW'(idx_q);
		unique case (state_q)
			ST_CLR: begin
				ram_we = 1'b1;
				ram_waddr = it_q[AW-1:0];
				ram_wdata = 32'd0;
			end
			ST_ADD_WR: begin
				ram_we = 1'b1;
			end
			ST_PK_M: ram_raddr = AW'(b0_q);
			ST_PK_R: ram_raddr = AW'(r_idx_q);
			default: ;
		endcase
	end

	logic signed [34:0] lr_full;
	logic [34:0] lr_abs;
	assign lr_full = $signed({3'b000, l_q}) - $signed({3'b000, r_cnt});
	assign lr_abs = lr_full[34] ? 35'(-lr_full) : 35'(lr_full);
	assign d_mag = d_val[34] ? 35'(-d_val) : 35'(d_val);

	logic [31:0] q2;
	assign q2 = quo_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			it_q <= '0;
			clr_rsp_q <= 1'b0;
			tot_q <= 32'd0;
			done_q <= 1'b0;
			rv_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						b0_q <= {1'b0, req.bin_index};
						b0_weight_q <= req.weight;
						val_q <= 32'd0;
						ang_q <= 16'sd0;
						sts_q <= chpe_pkg::STS_OK;
						acc_q <= 41'd0;
						rv_q <= 1'b0;
						flat_q <= 1'b0;
						unique case (req.cmd)
							chpe_pkg::CMD_ADD: begin
								if ({1'b0, req.bin_index} >= n_eff) begin
									sts_q <= chpe_pkg::STS_RANGE;
									done_q <= 1'b1;
								end else begin
									idx_q <= {1'b0, req.bin_index};
									state_q <= ST_ADD_RD;
								end
							end
							chpe_pkg::CMD_SUM: begin
								if ({1'b0, req.bin_index} >= n_eff
									|| {1'b0, req.last_bin} >= n_eff) begin
									sts_q <= chpe_pkg::STS_RANGE;
									done_q <= 1'b1;
								end else begin
									idx_q <= {1'b0, req.bin_index};
									end_q <= {1'b0, req.last_bin};
									max_mode_q <= 1'b0;
									state_q <= ST_WALK;
								end
							end
							chpe_pkg::CMD_MAX: begin
								idx_q <= 9'd0;
								end_q <= n_eff - 9'd1;
								max_mode_q <= 1'b1;
								state_q <= ST_WALK;
							end
							chpe_pkg::CMD_PEAK: begin
								if ({1'b0, req.bin_index} >= n_eff) begin
									sts_q <= chpe_pkg::STS_RANGE;
									done_q <= 1'b1;
								end else if (req.refine) begin
									idx_q <= nb_l;
									r_idx_q <= nb_r;
									state_q <= ST_PK_L;
								end else begin
									x_q <= $signed({36'd0, req.bin_index, 8'd0} <<< 8);
									state_q <= ST_ANG;
								end
							end
							chpe_pkg::CMD_CLEAR: begin
								tot_q <= 32'd0;
								it_q <= '0;
								clr_rsp_q <= 1'b1;
								state_q <= ST_CLR;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				ST_CLR: begin
					if (it_q == CW'(MAX_BINS - 1)) begin
						state_q <= ST_IDLE;
						done_q <= clr_rsp_q;
						clr_rsp_q <= 1'b0;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				ST_ADD_RD: state_q <= ST_ADD_WR;
				ST_ADD_WR: begin
					tot_q <= tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_WALK, ST_WEND: begin
					if (rv_q) begin
						if (max_mode_q) begin
							if ({9'd0, ram_rdata} > acc_q) begin
								acc_q <= {9'd0, ram_rdata};
							end
						end else begin
							acc_q <= acc_q + {9'd0, ram_rdata};
						end
					end
					if (state_q == ST_WALK) begin
						rv_q <= 1'b1;
						if (idx_q == end_q) begin
							state_q <= ST_WEND;
						end else begin
							idx_q <= idx_next;
						end
					end else begin
						rv_q <= 1'b0;
						state_q <= ST_FIN;
					end
				end
				ST_PK_L: state_q <= ST_PK_M;
				ST_PK_M: begin
					l_q <= ram_rdata;
					state_q <= ST_PK_R;
				end
				ST_PK_R: begin
					m_q <= ram_rdata;
					state_q <= ST_PK_D;
				end
				ST_PK_D: begin
					if (d_val == 35'sd0) begin
						flat_q <= 1'b1;
						x_q <= $signed({27'd0, b0_q, 16'd0});
						state_q <= ST_ANG;
					end else begin
						qneg_q <= lr_full[34] ^ d_val[34];
						quo_q <= {13'd0, lr_abs, 16'd0} + {29'd0, d_mag};
						div_q <= {4'd0, d_mag[34:0], 1'b0};
						rem_q <= 40'd0;
						it_q <= '0;
						state_q <= ST_DIV1;
					end
				end
				ST_DIV1, ST_DIV2: begin
					rem_q <= trial_ok ? trial[39:0] : {rem_q[38:0], quo_q[63]};
					quo_q <= {quo_q[62:0], trial_ok};
					it_q <= it_q + 1'b1;
					if (it_q == CW'(63)) begin
						state_q <= (state_q == ST_DIV1) ? ST_POS : ST_FIN;
					end
				end
				ST_POS: begin
					x_q <= qneg_q ? $signed({27'd0, b0_q, 16'd0}) + $signed({1'b0, quo_q[50:0]})
						: $signed({27'd0, b0_q, 16'd0}) - $signed({1'b0, quo_q[50:0]});
					state_q <= ST_ANG;
				end
				ST_ANG: begin
					qneg_q <= u_val[51];
					mul_q <= u_val[51] ? 33'(-u_val) : 33'(u_val);
					prod_q <= 66'd0;
					it_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q <= {prod_q[64:0], 1'b0} + (mul_q[32] ? {35'd0, chpe_pkg::PI_Q29} : 66'd0);
					mul_q <= {mul_q[31:0], 1'b0};
					it_q <= it_q + 1'b1;
					if (it_q == CW'(32)) begin
						state_q <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					quo_q <= {30'd0, prod_rnd[65:32]};
					div_q <= {31'd0, n_eff};
					rem_q <= 40'd0;
					it_q <= '0;
					state_q <= ST_DIV2;
				end
				ST_FIN: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
					if (flat_q) begin
						sts_q <= chpe_pkg::STS_FLAT;
					end
					if (is_peak_q) begin
						if (qneg_q) begin
							ang_q <= (quo_q > 64'd32768) ? 16'sh8000 : 16'(-q2);
						end else begin
							ang_q <= (quo_q > 64'd32767) ? 16'sh7FFF : 16'(q2);
						end
					end else begin
						val_q <= max_mode_q ? acc_q[31:0] : acc_q[39:8];
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Marks a peak-angle request so the final state formats an angle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_peak_q <= 1'b0;
		end else if (accept) begin
			is_peak_q <= (req.cmd == chpe_pkg::CMD_PEAK);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp = '{value: val_q, angle: ang_q, status: sts_q, total_weight: tot_q};

endmodule

// File: rtl/chpe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module chpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
